// File: hw/rtl/bfmh_pkg.sv
// Shared types and constants for the Bloom filter with MurmurHash3 double hashing.
// No dependencies; used by bloom_filter_murmur_double_hash.
package bfmh_pkg;

    // MurmurHash3 x64_128 constants
    localparam logic [63:0] MIX_C1    = 64'h87c37b91114253d5;
    localparam logic [63:0] MIX_C2    = 64'h4cf5ad432745937f;
    localparam logic [63:0] FIN_M1    = 64'hff51afd7ed558ccd;
    localparam logic [63:0] FIN_M2    = 64'hc4ceb9fe1a85ec53;
    localparam logic [63:0] MIX_ADD_A = 64'h0000000052dce729;
    localparam logic [63:0] MIX_ADD_B = 64'h0000000038495ab5;

    // Register reset values
    localparam logic [16:0] NUM_BITS_RST    = 17'd65536;
    localparam logic [4:0]  NUM_HASHES_RST  = 5'd7;
    localparam logic [63:0] SEED_FIRST_RST  = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] SEED_SECOND_RST = 64'hC6A4A7935BD1E995;

    typedef enum logic [1:0] {
        KIND_ADD       = 2'd0,
        KIND_QUERY     = 2'd1,
        KIND_CHECK_ADD = 2'd2,
        KIND_CLEAR     = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        REG_NUM_BITS    = 2'd0,
        REG_NUM_HASHES  = 2'd1,
        REG_SEED_FIRST  = 2'd2,
        REG_SEED_SECOND = 2'd3
    } reg_index_t;

    typedef enum logic [17:0] {
        ST_CLR  = 18'h00001,
        ST_IDLE = 18'h00002,
        ST_HSEL = 18'h00004,
        ST_LA1  = 18'h00008,
        ST_LA2  = 18'h00010,
        ST_UPA  = 18'h00020,
        ST_LB1  = 18'h00040,
        ST_LB2  = 18'h00080,
        ST_UPB  = 18'h00100,
        ST_FIN  = 18'h00200,
        ST_F1   = 18'h00400,
        ST_F2   = 18'h00800,
        ST_MOD  = 18'h01000,
        ST_RD   = 18'h02000,
        ST_TEST = 18'h04000,
        ST_SRD  = 18'h08000,
        ST_SWR  = 18'h10000,
        ST_OUT  = 18'h20000
    } state_t;

    function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned r);
        return (x << r) | (x >> (64 - r));
    endfunction

endpackage

// File: hw/rtl/bloom_filter_murmur_double_hash.sv
// Bloom filter over an on-chip bit store, keyed by MurmurHash3 x64_128 double hashing.
// Depends on bfmh_pkg (constants, state encoding, rotate helper).
//
// A key streams in as 64-bit little-endian words, one transaction per word, the last
// one flagged by s_last; only the final word (or a clear) yields a result transaction.
// A word that only fills the first half of a 16-byte block is just held.
// Completing a block runs both seeds, four 64x64 multiplies each, with every multiply
// taking three passes through one shared 32x32 multiplier. The last word adds the
// tail step and the finalizer, and then each of the k probes runs a bit-serial modulo
// reduction plus a store read; add and check-and-add then run a read-modify-write per
// probe on the store that sets its bit.
// After reset and on every clear the store is swept one 64-bit word per cycle over its
// STORE_BITS/64 words (1024 by default), with s_ready low; configuration writes are
// taken at any time. A pending result sits in the output register while the next key
// streams in.
module bloom_filter_murmur_double_hash #(
    parameter int STORE_BITS = 65536,
    parameter int MAX_PROBES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    // key word channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [63:0] s_data_word,
    input  logic [3:0]  s_byte_count,
    input  logic        s_last,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_present,
    output logic [31:0] m_items_total
);

    localparam int STORE_WORDS = (STORE_BITS + 63) / 64;
    localparam int WORD_AW     = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam int IDXW        = $clog2(STORE_BITS);
    localparam int MW          = $clog2(STORE_BITS + 1);
    localparam int PCW         = $clog2(MAX_PROBES + 1);
    localparam int PAW         = (MAX_PROBES > 1) ? $clog2(MAX_PROBES) : 1;
    localparam logic [1:0]  MUL_LAST  = 2'd2;
    localparam logic [31:0] COUNT_MAX = 32'hFFFFFFFF;

    // configuration registers
    logic [16:0] num_bits_reg;
    logic [4:0]  num_hashes_reg;
    logic [63:0] seed1_reg, seed2_reg;

    // control and datapath registers
    bfmh_pkg::state_t state_reg, state_next;
    logic [31:0] items_reg, items_next;
    logic [63:0] ha1_reg, hb1_reg, ha2_reg, hb2_reg;
    logic [63:0] ha1_next, hb1_next, ha2_next, hb2_next;
    logic [63:0] held_reg, held_next;
    logic        half_reg, half_next;
    logic [63:0] len_reg, len_next;
    logic [63:0] word_reg, word_next;
    logic [1:0]  kind_reg, kind_next;
    logic        last_reg, last_next;
    logic        halfat_reg, halfat_next;
    logic        cnt0_reg, cnt0_next;
    logic        blk_reg, blk_next;
    logic        sel_reg, sel_next;
    logic        fm_sel_reg, fm_sel_next;
    logic [63:0] mulx_reg, mulx_next;
    logic [63:0] acc_reg, acc_next;
    logic [1:0]  mc_reg, mc_next;
    logic [63:0] h1_reg, h1_next, h2_reg, h2_next;
    logic [63:0] pv_reg, pv_next;
    logic [MW-1:0] rem_reg, rem_next;
    logic [5:0]  bitcnt_reg, bitcnt_next;
    logic [PCW-1:0] pc_reg, pc_next;
    logic [IDXW-1:0] pidx_reg [MAX_PROBES];
    logic [IDXW-1:0] pidx_next [MAX_PROBES];
    logic        present_reg, present_next;
    logic [WORD_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic        clr_out_reg, clr_out_next;
    logic        m_valid_reg, m_valid_next;
    logic        m_present_reg, m_present_next;
    logic [31:0] m_items_reg, m_items_next;

    // bit store
    logic [63:0] mem [STORE_WORDS];
    logic [63:0] mem_rdata_reg;
    logic        mem_we;
    logic [WORD_AW-1:0] mem_raddr, mem_waddr;
    logic [63:0] mem_wdata;

    // misc combinational
    logic        s_acc;
    logic [3:0]  cnt_eff;
    logic [63:0] w_in;
    logic [MW-1:0]  m_eff;
    logic [PCW-1:0] k_eff;
    logic        need_a, need_b;
    logic [63:0] cur_a, cur_b;
    logic [63:0] mul_c;
    logic [31:0] mul_opa, mul_opb;
    logic [63:0] mul_prod, mul_res;
    logic [IDXW-1:0] cur_idx;
    logic [63:0] bit_mask;
    logic [MW:0] trial;
    logic [MW-1:0] rem_step;
    logic [PCW-1:0] pc_inc;
    logic        more_probes;

    assign s_ready       = (state_reg == bfmh_pkg::ST_IDLE);
    assign s_acc         = s_valid & s_ready;
    assign m_valid       = m_valid_reg;
    assign m_present     = m_present_reg;
    assign m_items_total = m_items_reg;

    // configuration writes, accepted at any time
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_bits_reg   <= bfmh_pkg::NUM_BITS_RST;
            num_hashes_reg <= bfmh_pkg::NUM_HASHES_RST;
            seed1_reg      <= bfmh_pkg::SEED_FIRST_RST;
            seed2_reg      <= bfmh_pkg::SEED_SECOND_RST;
        end else if (cfg_we) begin
            unique case (bfmh_pkg::reg_index_t'(cfg_index))
                bfmh_pkg::REG_NUM_BITS:    num_bits_reg   <= cfg_data[16:0];
                bfmh_pkg::REG_NUM_HASHES:  num_hashes_reg <= cfg_data[4:0];
                bfmh_pkg::REG_SEED_FIRST:  seed1_reg      <= cfg_data;
                bfmh_pkg::REG_SEED_SECOND: seed2_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    // clamp modulus and probe count to the supported range
    always_comb begin
        if (32'(num_bits_reg) > 32'(STORE_BITS)) begin
            m_eff = MW'(STORE_BITS);
        end else if (num_bits_reg < 17'd64) begin
            m_eff = MW'(64);
        end else begin
            m_eff = MW'(num_bits_reg);
        end
        if (num_hashes_reg == 5'd0) begin
            k_eff = PCW'(1);
        end else if (32'(num_hashes_reg) > 32'(MAX_PROBES)) begin
            k_eff = PCW'(MAX_PROBES);
        end else begin
            k_eff = PCW'(num_hashes_reg);
        end
    end

    // byte count: full word unless this is the last one; mask unused bytes
    always_comb begin
        cnt_eff = (!s_last || s_byte_count > 4'd8) ? 4'd8 : s_byte_count;
        for (int b = 0; b < 8; b++) begin
            w_in[8*b +: 8] = (4'(b) < cnt_eff) ? s_data_word[8*b +: 8] : 8'h00;
        end
    end

    assign need_a = blk_reg | halfat_reg | ~cnt0_reg;
    assign need_b = blk_reg | (halfat_reg & ~cnt0_reg);
    assign cur_a  = sel_reg ? ha2_reg : ha1_reg;
    assign cur_b  = sel_reg ? hb2_reg : hb1_reg;

    // shared multiplier: low 64 bits of x*c in three 32x32 passes
    always_comb begin
        case (state_reg)
            bfmh_pkg::ST_LA1: mul_c = bfmh_pkg::MIX_C1;
            bfmh_pkg::ST_LA2: mul_c = bfmh_pkg::MIX_C2;
            bfmh_pkg::ST_LB1: mul_c = bfmh_pkg::MIX_C2;
            bfmh_pkg::ST_LB2: mul_c = bfmh_pkg::MIX_C1;
            bfmh_pkg::ST_F1:  mul_c = bfmh_pkg::FIN_M1;
            bfmh_pkg::ST_F2:  mul_c = bfmh_pkg::FIN_M2;
            default:          mul_c = 64'd0;
        endcase
        mul_opa  = (mc_reg == MUL_LAST) ? mulx_reg[63:32] : mulx_reg[31:0];
        mul_opb  = (mc_reg == 2'd1) ? mul_c[63:32] : mul_c[31:0];
        mul_prod = 64'(mul_opa) * 64'(mul_opb);
        mul_res  = (mc_reg == 2'd0) ? mul_prod : acc_reg + {mul_prod[31:0], 32'd0};
    end

    // probe helpers
    assign cur_idx     = pidx_reg[pc_reg[PAW-1:0]];
    assign bit_mask    = 64'd1 << cur_idx[5:0];
    assign trial       = {rem_reg, pv_reg[~bitcnt_reg]};
    assign rem_step    = (trial >= {1'b0, m_eff}) ? MW'(trial - {1'b0, m_eff}) : trial[MW-1:0];
    assign pc_inc      = pc_reg + PCW'(1);
    assign more_probes = (pc_inc < k_eff);

    // store port control
    assign mem_raddr = WORD_AW'(cur_idx >> 6);
    assign mem_we    = (state_reg == bfmh_pkg::ST_CLR) || (state_reg == bfmh_pkg::ST_SWR);
    assign mem_waddr = (state_reg == bfmh_pkg::ST_CLR) ? clr_cnt_reg : mem_raddr;
    assign mem_wdata = (state_reg == bfmh_pkg::ST_CLR) ? 64'd0 : (mem_rdata_reg | bit_mask);

    always_comb begin
        logic        seq_done;
        logic [63:0] t, s, v, fa, fb;

        state_next     = state_reg;
        items_next     = items_reg;
        ha1_next       = ha1_reg;
        hb1_next       = hb1_reg;
        ha2_next       = ha2_reg;
        hb2_next       = hb2_reg;
        held_next      = held_reg;
        half_next      = half_reg;
        len_next       = len_reg;
        word_next      = word_reg;
        kind_next      = kind_reg;
        last_next      = last_reg;
        halfat_next    = halfat_reg;
        cnt0_next      = cnt0_reg;
        blk_next       = blk_reg;
        sel_next       = sel_reg;
        fm_sel_next    = fm_sel_reg;
        mulx_next      = mulx_reg;
        acc_next       = acc_reg;
        mc_next        = mc_reg;
        h1_next        = h1_reg;
        h2_next        = h2_reg;
        pv_next        = pv_reg;
        rem_next       = rem_reg;
        bitcnt_next    = bitcnt_reg;
        pc_next        = pc_reg;
        pidx_next      = pidx_reg;
        present_next   = present_reg;
        clr_cnt_next   = clr_cnt_reg;
        clr_out_next   = clr_out_reg;
        m_valid_next   = m_valid_reg & ~m_ready;
        m_present_next = m_present_reg;
        m_items_next   = m_items_reg;
        seq_done       = 1'b0;
        t              = acc_reg;
        s              = 64'd0;
        v              = 64'd0;
        fa             = 64'd0;
        fb             = 64'd0;

        unique case (state_reg)
            bfmh_pkg::ST_CLR: begin
                clr_cnt_next = clr_cnt_reg + WORD_AW'(1);
                if (clr_cnt_reg == WORD_AW'(STORE_WORDS - 1)) begin
                    clr_out_next = 1'b0;
                    state_next   = clr_out_reg ? bfmh_pkg::ST_OUT : bfmh_pkg::ST_IDLE;
                end
            end
            bfmh_pkg::ST_IDLE: begin
                if (s_acc) begin
                    if (s_kind == bfmh_pkg::KIND_CLEAR) begin
                        len_next     = 64'd0;
                        half_next    = 1'b0;
                        items_next   = 32'd0;
                        present_next = 1'b0;
                        clr_cnt_next = '0;
                        clr_out_next = 1'b1;
                        state_next   = bfmh_pkg::ST_CLR;
                    end else begin
                        // a new key starts from the seeds in force now
                        if (len_reg == 64'd0 && !half_reg) begin
                            ha1_next = seed1_reg;
                            hb1_next = seed1_reg;
                            ha2_next = seed2_reg;
                            hb2_next = seed2_reg;
                        end
                        len_next    = len_reg + 64'(cnt_eff);
                        word_next   = w_in;
                        kind_next   = s_kind;
                        last_next   = s_last;
                        halfat_next = half_reg;
                        cnt0_next   = (cnt_eff == 4'd0);
                        blk_next    = half_reg && (!s_last || cnt_eff == 4'd8);
                        sel_next    = 1'b0;
                        if (!s_last && !half_reg) begin
                            held_next = w_in;
                            half_next = 1'b1;
                        end else begin
                            state_next = bfmh_pkg::ST_HSEL;
                        end
                    end
                end
            end
            bfmh_pkg::ST_HSEL: begin
                if (need_a) begin
                    mulx_next  = halfat_reg ? held_reg : word_reg;
                    mc_next    = 2'd0;
                    state_next = bfmh_pkg::ST_LA1;
                end else begin
                    state_next = bfmh_pkg::ST_FIN;
                end
            end
            bfmh_pkg::ST_LA1, bfmh_pkg::ST_LB1: begin
                acc_next = mul_res;
                mc_next  = mc_reg + 2'd1;
                if (mc_reg == MUL_LAST) begin
                    mc_next = 2'd0;
                    if (state_reg == bfmh_pkg::ST_LA1) begin
                        mulx_next  = bfmh_pkg::rotl64(mul_res, 31);
                        state_next = bfmh_pkg::ST_LA2;
                    end else begin
                        mulx_next  = bfmh_pkg::rotl64(mul_res, 33);
                        state_next = bfmh_pkg::ST_LB2;
                    end
                end
            end
            bfmh_pkg::ST_LA2, bfmh_pkg::ST_LB2: begin
                acc_next = mul_res;
                mc_next  = mc_reg + 2'd1;
                if (mc_reg == MUL_LAST) begin
                    mc_next    = 2'd0;
                    state_next = (state_reg == bfmh_pkg::ST_LA2) ? bfmh_pkg::ST_UPA
                                                                 : bfmh_pkg::ST_UPB;
                end
            end
            bfmh_pkg::ST_UPA: begin
                if (blk_reg) begin
                    s = bfmh_pkg::rotl64(cur_a ^ t, 27) + cur_b;
                    v = s + (s << 2) + bfmh_pkg::MIX_ADD_A;
                end else begin
                    v = cur_a ^ t;
                end
                if (sel_reg) ha2_next = v;
                else         ha1_next = v;
                if (need_b) begin
                    mulx_next  = word_reg;
                    mc_next    = 2'd0;
                    state_next = bfmh_pkg::ST_LB1;
                end else if (last_reg) begin
                    state_next = bfmh_pkg::ST_FIN;
                end else begin
                    seq_done = 1'b1;
                end
            end
            bfmh_pkg::ST_UPB: begin
                if (blk_reg) begin
                    s = bfmh_pkg::rotl64(cur_b ^ t, 31) + cur_a;
                    v = s + (s << 2) + bfmh_pkg::MIX_ADD_B;
                end else begin
                    v = cur_b ^ t;
                end
                if (sel_reg) hb2_next = v;
                else         hb1_next = v;
                if (last_reg) state_next = bfmh_pkg::ST_FIN;
                else          seq_done   = 1'b1;
            end
            bfmh_pkg::ST_FIN: begin
                fa = (cur_a ^ len_reg) + (cur_b ^ len_reg);
                fb = (cur_b ^ len_reg) + fa;
                if (sel_reg) begin
                    ha2_next = fa;
                    hb2_next = fb;
                end else begin
                    ha1_next = fa;
                    hb1_next = fb;
                end
                mulx_next   = fa ^ (fa >> 33);
                fm_sel_next = 1'b0;
                mc_next     = 2'd0;
                state_next  = bfmh_pkg::ST_F1;
            end
            bfmh_pkg::ST_F1: begin
                acc_next = mul_res;
                mc_next  = mc_reg + 2'd1;
                if (mc_reg == MUL_LAST) begin
                    mc_next    = 2'd0;
                    mulx_next  = mul_res ^ (mul_res >> 33);
                    state_next = bfmh_pkg::ST_F2;
                end
            end
            bfmh_pkg::ST_F2: begin
                acc_next = mul_res;
                mc_next  = mc_reg + 2'd1;
                if (mc_reg == MUL_LAST) begin
                    mc_next = 2'd0;
                    v       = mul_res ^ (mul_res >> 33);
                    if (!fm_sel_reg) begin
                        if (sel_reg) ha2_next = v;
                        else         ha1_next = v;
                        fm_sel_next = 1'b1;
                        mulx_next   = cur_b ^ (cur_b >> 33);
                        state_next  = bfmh_pkg::ST_F1;
                    end else begin
                        if (sel_reg) begin
                            hb2_next = v;
                            h2_next  = cur_a + v;
                        end else begin
                            hb1_next = v;
                            h1_next  = cur_a + v;
                        end
                        seq_done = 1'b1;
                    end
                end
            end
            bfmh_pkg::ST_MOD: begin
                // restoring reduction, one bit of the probe value per cycle, MSB first
                rem_next    = rem_step;
                bitcnt_next = bitcnt_reg + 6'd1;
                if (bitcnt_reg == 6'd63) begin
                    pidx_next[pc_reg[PAW-1:0]] = IDXW'(rem_step);
                    state_next = bfmh_pkg::ST_RD;
                end
            end
            bfmh_pkg::ST_RD: begin
                state_next = bfmh_pkg::ST_TEST;
            end
            bfmh_pkg::ST_TEST: begin
                present_next = present_reg & ((mem_rdata_reg & bit_mask) != 64'd0);
                if (more_probes) begin
                    pc_next     = pc_inc;
                    pv_next     = pv_reg + h2_reg;
                    rem_next    = '0;
                    bitcnt_next = 6'd0;
                    state_next  = bfmh_pkg::ST_MOD;
                end else if (kind_reg == bfmh_pkg::KIND_QUERY) begin
                    state_next = bfmh_pkg::ST_OUT;
                end else begin
                    pc_next    = '0;
                    state_next = bfmh_pkg::ST_SRD;
                end
            end
            bfmh_pkg::ST_SRD: begin
                state_next = bfmh_pkg::ST_SWR;
            end
            bfmh_pkg::ST_SWR: begin
                if (more_probes) begin
                    pc_next    = pc_inc;
                    state_next = bfmh_pkg::ST_SRD;
                end else begin
                    if ((kind_reg == bfmh_pkg::KIND_ADD || !present_reg)
                            && items_reg != COUNT_MAX) begin
                        items_next = items_reg + 32'd1;
                    end
                    state_next = bfmh_pkg::ST_OUT;
                end
            end
            bfmh_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_present_next = present_reg;
                    m_items_next   = items_reg;
                    state_next     = bfmh_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bfmh_pkg::ST_IDLE;
            end
        endcase

        // end of one seed's pass
        if (seq_done) begin
            if (!sel_reg) begin
                sel_next   = 1'b1;
                state_next = bfmh_pkg::ST_HSEL;
            end else if (last_reg) begin
                len_next     = 64'd0;
                half_next    = 1'b0;
                pv_next      = h1_reg;
                pc_next      = '0;
                present_next = 1'b1;
                rem_next     = '0;
                bitcnt_next  = 6'd0;
                state_next   = bfmh_pkg::ST_MOD;
            end else begin
                half_next  = 1'b0;
                state_next = bfmh_pkg::ST_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bfmh_pkg::ST_CLR;
            items_reg   <= 32'd0;
            half_reg    <= 1'b0;
            len_reg     <= 64'd0;
            held_reg    <= 64'd0;
            sel_reg     <= 1'b0;
            fm_sel_reg  <= 1'b0;
            mc_reg      <= 2'd0;
            bitcnt_reg  <= 6'd0;
            pc_reg      <= '0;
            clr_cnt_reg <= '0;
            clr_out_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            items_reg   <= items_next;
            half_reg    <= half_next;
            len_reg     <= len_next;
            held_reg    <= held_next;
            sel_reg     <= sel_next;
            fm_sel_reg  <= fm_sel_next;
            mc_reg      <= mc_next;
            bitcnt_reg  <= bitcnt_next;
            pc_reg      <= pc_next;
            clr_cnt_reg <= clr_cnt_next;
            clr_out_reg <= clr_out_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        ha1_reg       <= ha1_next;
        hb1_reg       <= hb1_next;
        ha2_reg       <= ha2_next;
        hb2_reg       <= hb2_next;
        word_reg      <= word_next;
        kind_reg      <= kind_next;
        last_reg      <= last_next;
        halfat_reg    <= halfat_next;
        cnt0_reg      <= cnt0_next;
        blk_reg       <= blk_next;
        mulx_reg      <= mulx_next;
        acc_reg       <= acc_next;
        h1_reg        <= h1_next;
        h2_reg        <= h2_next;
        pv_reg        <= pv_next;
        rem_reg       <= rem_next;
        pidx_reg      <= pidx_next;
        present_reg   <= present_next;
        m_present_reg <= m_present_next;
        m_items_reg   <= m_items_next;
    end

    // bit store: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_raddr];
    end

    // store is only touched by the sweep and the bit-set pass
    assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == bfmh_pkg::ST_CLR || state_reg == bfmh_pkg::ST_SWR))
        else $error("store written outside clear or set pass");

    // a clear transaction zeroes the key count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_kind == bfmh_pkg::KIND_CLEAR) |=> (items_reg == 32'd0))
        else $error("count not cleared");

    // probe counter stays inside the configured probe count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bfmh_pkg::ST_TEST || state_reg == bfmh_pkg::ST_SWR) |-> (pc_reg < k_eff))
        else $error("probe counter out of range");

    // count never drops except through a clear
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_acc && s_kind == bfmh_pkg::KIND_CLEAR) |=> (items_reg >= $past(items_reg)))
        else $error("count decreased");

    // reduced probe index is below the modulus
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bfmh_pkg::ST_RD) |-> (MW'(cur_idx) < m_eff))
        else $error("probe index beyond modulus");

endmodule

// File: verif/bloom_filter_murmur_double_hash_tb.sv
// Self-checking testbench for bloom_filter_murmur_double_hash: directed key table, then random keys.
// Depends on bfmh_pkg and the RTL only; holds its own MurmurHash3 / Bloom store predictor.
// Random stall on both channels, one long result-side hold-off, idle-cycle watchdog.
module bloom_filter_murmur_double_hash_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_BITS = 65536;
    localparam int MAX_PROBES = 16;
    localparam int STORE_WORDS = STORE_BITS / 64;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 300;   // a block absorb can still run after the last result
    localparam int HOLD_CYCLES = 3000;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_kind;
    logic [63:0] s_data_word;
    logic [3:0]  s_byte_count;
    logic        s_last;
    logic        m_valid;
    logic        m_ready;
    logic        m_present;
    logic [31:0] m_items_total;

    bloom_filter_murmur_double_hash #(
        .STORE_BITS(STORE_BITS),
        .MAX_PROBES(MAX_PROBES)
    ) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind), .s_data_word(s_data_word),
        .s_byte_count(s_byte_count), .s_last(s_last),
        .m_valid(m_valid), .m_ready(m_ready), .m_present(m_present),
        .m_items_total(m_items_total)
    );

    // 12 ns clock
    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Predictor state: the filter store, key count, hash lanes, config
    // ---------------------------------------------------------------
    typedef struct packed {
        logic        present;
        logic [31:0] total;
    } lookup_t;

    logic [63:0] filter_store [STORE_WORDS];
    logic [31:0] keys_counted;
    logic [63:0] base_a, base_b, stride_a, stride_b;
    logic [63:0] pending_word;
    logic        pending_half;
    logic [63:0] bytes_seen;
    logic [16:0] cfg_num_bits;
    logic [4:0]  cfg_num_hashes;
    logic [63:0] cfg_seed_first, cfg_seed_second;

    lookup_t expected_lookups[$];
    int      mismatches = 0;
    int      results_seen = 0;
    bit      quiet;          // no idling on either side while set

    function automatic logic [63:0] rot(input logic [63:0] x, input int r);
        return (x << r) | (x >> (64 - r));
    endfunction

    function automatic logic [63:0] avalanche(input logic [63:0] k);
        k = k ^ (k >> 33); k = k * bfmh_pkg::FIN_M1;
        k = k ^ (k >> 33); k = k * bfmh_pkg::FIN_M2;
        return k ^ (k >> 33);
    endfunction

    function automatic logic [63:0] scramble_lo(input logic [63:0] k);
        return rot(k * bfmh_pkg::MIX_C1, 31) * bfmh_pkg::MIX_C2;
    endfunction

    function automatic logic [63:0] scramble_hi(input logic [63:0] k);
        return rot(k * bfmh_pkg::MIX_C2, 33) * bfmh_pkg::MIX_C1;
    endfunction

    task automatic mix_block(inout logic [63:0] a, inout logic [63:0] b,
                             input logic [63:0] k1, input logic [63:0] k2);
        a = a ^ scramble_lo(k1);
        a = rot(a, 27) + b;
        a = a * 64'd5 + bfmh_pkg::MIX_ADD_A;
        b = b ^ scramble_hi(k2);
        b = rot(b, 31) + a;
        b = b * 64'd5 + bfmh_pkg::MIX_ADD_B;
    endtask

    function automatic logic [63:0] digest(input logic [63:0] a, input logic [63:0] b,
                                           input logic [63:0] len);
        a = a ^ len;
        b = b ^ len;
        a = a + b;
        b = b + a;
        return avalanche(a) + avalanche(b);
    endfunction

    task automatic wipe_store();
        foreach (filter_store[i]) filter_store[i] = '0;
        keys_counted = '0;
    endtask

    task automatic restart_key();
        pending_word = '0;
        pending_half = 1'b0;
        bytes_seen = '0;
        base_a = cfg_seed_first;
        base_b = cfg_seed_first;
        stride_a = cfg_seed_second;
        stride_b = cfg_seed_second;
    endtask

    // Advance the predictor by one accepted word; emits an expectation on last word or clear
    task automatic predict_word(input bfmh_pkg::kind_t kind, input logic [63:0] word,
                                input logic [3:0] cnt_in, input logic last,
                                output bit emits, output lookup_t res);
        logic [63:0] h1, h2, pos, modulus;
        logic [63:0] probe_pos [MAX_PROBES];
        int          nprobe;
        int unsigned cnt;
        bit          all_set;
        emits = 0;
        res = '0;
        if (kind == bfmh_pkg::KIND_CLEAR) begin
            wipe_store();
            restart_key();
            emits = 1;
            return;
        end
        if (bytes_seen == 0 && !pending_half) restart_key();
        cnt = cnt_in;
        if (!last || cnt > 8) cnt = 8;
        if (cnt < 8) word = word & ((64'd1 << (8 * cnt)) - 64'd1);
        bytes_seen = bytes_seen + 64'(cnt);
        if (!last) begin
            if (pending_half) begin
                mix_block(base_a, base_b, pending_word, word);
                mix_block(stride_a, stride_b, pending_word, word);
                pending_half = 1'b0;
            end else begin
                pending_word = word;
                pending_half = 1'b1;
            end
            return;
        end
        // tail step: only the lanes that hold bytes are folded in
        if (pending_half) begin
            if (cnt == 8) begin
                mix_block(base_a, base_b, pending_word, word);
                mix_block(stride_a, stride_b, pending_word, word);
            end else begin
                if (cnt > 0) begin
                    base_b = base_b ^ scramble_hi(word);
                    stride_b = stride_b ^ scramble_hi(word);
                end
                base_a = base_a ^ scramble_lo(pending_word);
                stride_a = stride_a ^ scramble_lo(pending_word);
            end
        end else if (cnt > 0) begin
            base_a = base_a ^ scramble_lo(word);
            stride_a = stride_a ^ scramble_lo(word);
        end
        h1 = digest(base_a, base_b, bytes_seen);
        h2 = digest(stride_a, stride_b, bytes_seen);
        restart_key();

        modulus = 64'(cfg_num_bits);
        if (modulus < 64'd64) modulus = 64'd64;
        if (modulus > 64'(STORE_BITS)) modulus = 64'(STORE_BITS);
        nprobe = int'(cfg_num_hashes);
        if (nprobe < 1) nprobe = 1;
        if (nprobe > MAX_PROBES) nprobe = MAX_PROBES;

        all_set = 1;
        for (int i = 0; i < nprobe; i++) begin
            pos = (h1 + 64'(i) * h2) % modulus;
            probe_pos[i] = pos;
            if (!filter_store[pos >> 6][pos[5:0]]) all_set = 0;
        end
        if (kind != bfmh_pkg::KIND_QUERY) begin
            for (int i = 0; i < nprobe; i++)
                filter_store[probe_pos[i] >> 6][probe_pos[i][5:0]] = 1'b1;
            if ((kind == bfmh_pkg::KIND_ADD || !all_set) && keys_counted != 32'hFFFF_FFFF)
                keys_counted = keys_counted + 32'd1;
        end
        emits = 1;
        res.present = all_set;
        res.total = keys_counted;
    endtask

    // ---------------------------------------------------------------
    // Key word sender
    // ---------------------------------------------------------------
    int next_gap;

    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(3, 1);
        if (r < 98) return $urandom_range(40, 5);
        return $urandom_range(300, 100);
    endfunction

    // Offer one word; returns at the edge where it was accepted. When the next word is to
    // follow back to back, s_valid stays high and the next call only replaces the payload.
    task automatic send_word(input bfmh_pkg::kind_t kind, input logic [63:0] word,
                             input logic [3:0] cnt, input logic last,
                             input bit typed, input lookup_t typed_res);
        bit      emits;
        lookup_t res;
        lookup_t want;
        repeat (next_gap) @(posedge aclk);
        s_valid <= 1'b1;
        s_kind <= kind;
        s_data_word <= word;
        s_byte_count <= cnt;
        s_last <= last;
        do @(posedge aclk); while (!s_ready);
        predict_word(kind, word, cnt, last, emits, res);
        if (emits) begin
            want = typed ? typed_res : res;
            expected_lookups = {expected_lookups, want};
        end
        next_gap = pick_gap();
        if (next_gap > 0) s_valid <= 1'b0;
    endtask

    // Lower valid at the acceptance edge, drain expectations, then let any trailing absorb finish
    task automatic drain_block();
        if (next_gap == 0) s_valid <= 1'b0;
        next_gap = 0;
        while (expected_lookups.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Enable stays high across back-to-back writes; the caller lowers it
    task automatic write_reg(input bfmh_pkg::reg_index_t idx, input logic [63:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        case (idx)
            bfmh_pkg::REG_NUM_BITS:    cfg_num_bits = value[16:0];
            bfmh_pkg::REG_NUM_HASHES:  cfg_num_hashes = value[4:0];
            bfmh_pkg::REG_SEED_FIRST:  cfg_seed_first = value;
            bfmh_pkg::REG_SEED_SECOND: cfg_seed_second = value;
        endcase
    endtask

    task automatic configure(input logic [63:0] nbits, input logic [63:0] nhash,
                             input logic [63:0] seed_a, input logic [63:0] seed_b);
        drain_block();
        write_reg(bfmh_pkg::REG_NUM_BITS, nbits);
        write_reg(bfmh_pkg::REG_NUM_HASHES, nhash);
        write_reg(bfmh_pkg::REG_SEED_FIRST, seed_a);
        write_reg(bfmh_pkg::REG_SEED_SECOND, seed_b);
        cfg_we <= 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Directed table
    // ---------------------------------------------------------------
    typedef struct {
        bfmh_pkg::kind_t kind;
        logic [63:0]     word;
        logic [3:0]      cnt;
        logic            last;
        bit              typed;
        lookup_t         res;
    } key_row_t;

    key_row_t key_table[$];

    function automatic key_row_t row(input bfmh_pkg::kind_t kind, input logic [63:0] word,
                                     input logic [3:0] cnt, input logic last,
                                     input bit typed = 0, input logic present = 0,
                                     input logic [31:0] total = 0);
        key_row_t r;
        r.kind = kind; r.word = word; r.cnt = cnt; r.last = last;
        r.typed = typed; r.res.present = present; r.res.total = total;
        return r;
    endfunction

    task automatic table_add(input key_row_t r);
        key_table = {key_table, r};
    endtask

    localparam logic [63:0] KEY_A = 64'h0123_4567_89AB_CDEF;

    task automatic build_table();
        // one short key walked through query, add and check-and-add on a fresh store
        table_add(row(bfmh_pkg::KIND_QUERY,     KEY_A, 4'd8, 1'b1, 1, 1'b0, 32'd0));
        table_add(row(bfmh_pkg::KIND_ADD,       KEY_A, 4'd8, 1'b1, 1, 1'b0, 32'd1));
        table_add(row(bfmh_pkg::KIND_QUERY,     KEY_A, 4'd8, 1'b1, 1, 1'b1, 32'd1));
        table_add(row(bfmh_pkg::KIND_CHECK_ADD, KEY_A, 4'd8, 1'b1, 1, 1'b1, 32'd1));
        table_add(row(bfmh_pkg::KIND_ADD,       KEY_A, 4'd8, 1'b1, 1, 1'b1, 32'd2));
        table_add(row(bfmh_pkg::KIND_CHECK_ADD, '1,    4'd8, 1'b1));
        // empty key, and an oversize byte count that saturates to eight
        table_add(row(bfmh_pkg::KIND_ADD,       '0,    4'd0,  1'b1));
        table_add(row(bfmh_pkg::KIND_QUERY,     '1,    4'd15, 1'b1));
        // kind and byte count on an earlier word are ignored; full 16-byte block
        table_add(row(bfmh_pkg::KIND_QUERY,     64'hFEDC_BA98_7654_3210, 4'd3, 1'b0));
        table_add(row(bfmh_pkg::KIND_CHECK_ADD, 64'h8000_0000_0000_0001, 4'd8, 1'b1));
        // one block then a lone tail word
        table_add(row(bfmh_pkg::KIND_QUERY,     64'h5555_5555_5555_5555, 4'd0, 1'b0));
        table_add(row(bfmh_pkg::KIND_ADD,       64'hAAAA_AAAA_AAAA_AAAA, 4'd15, 1'b0));
        table_add(row(bfmh_pkg::KIND_QUERY,     64'hAAAA_AAAA_AAAA_AAAA, 4'd5, 1'b1));
        // half block closed by a last word with no bytes
        table_add(row(bfmh_pkg::KIND_ADD,       64'h0F0F_0F0F_0F0F_0F0F, 4'd8, 1'b0));
        table_add(row(bfmh_pkg::KIND_ADD,       '1,    4'd0, 1'b1));
        // clear arriving mid-key drops the partial key and wipes the count
        table_add(row(bfmh_pkg::KIND_ADD,       64'h1234_5678_9ABC_DEF0, 4'd8, 1'b0));
        table_add(row(bfmh_pkg::KIND_CLEAR,     '1,    4'd15, 1'b0, 1, 1'b0, 32'd0));
        table_add(row(bfmh_pkg::KIND_QUERY,     KEY_A, 4'd8, 1'b1, 1, 1'b0, 32'd0));
        // longer key ending on a single byte
        table_add(row(bfmh_pkg::KIND_ADD,       64'h0000_0000_0000_0001, 4'd8, 1'b0));
        table_add(row(bfmh_pkg::KIND_CHECK_ADD, 64'h7FFF_FFFF_FFFF_FFFF, 4'd8, 1'b0));
        table_add(row(bfmh_pkg::KIND_QUERY,     64'hC3C3_C3C3_C3C3_C3C3, 4'd8, 1'b0));
        table_add(row(bfmh_pkg::KIND_CHECK_ADD, 64'hFFFF_FFFF_FFFF_FF9A, 4'd1, 1'b1));
    endtask

    // ---------------------------------------------------------------
    // Random keys: a pool of remembered keys so queries and re-adds hit
    // ---------------------------------------------------------------
    typedef struct {
        logic [31:0] tag;
        int          nwords;
        logic [3:0]  tail_cnt;
    } key_desc_t;

    key_desc_t key_pool[16];

    function automatic key_desc_t fresh_key(input int max_words);
        key_desc_t d;
        d.tag = $urandom;
        d.nwords = ($urandom_range(9) == 0) ? $urandom_range(max_words, 1)
                                            : $urandom_range(4, 1);
        d.tail_cnt = 4'($urandom_range(15));
        return d;
    endfunction

    function automatic logic [63:0] key_word(input logic [31:0] tag, input int j);
        return {tag, tag ^ 32'(j)} * 64'h9E37_79B9_7F4A_7C15 ^ {32'(j), ~tag};
    endfunction

    task automatic random_keys(input int n_words, input int max_words);
        key_desc_t       d;
        bfmh_pkg::kind_t k;
        int              slot;
        int              sent;
        lookup_t         none;
        none = '0;
        sent = 0;
        foreach (key_pool[i]) key_pool[i] = fresh_key(max_words);
        while (sent < n_words) begin
            if ($urandom_range(199) == 0) begin
                send_word(bfmh_pkg::KIND_CLEAR, {$urandom, $urandom}, 4'($urandom),
                          1'($urandom), 0, none);
                sent++;
                continue;
            end
            slot = $urandom_range(15);
            if ($urandom_range(9) < 4) begin
                d = fresh_key(max_words);
                key_pool[slot] = d;
            end else begin
                d = key_pool[slot];
            end
            for (int j = 0; j < d.nwords - 1; j++) begin
                // earlier words: random kind (never clear) and ignored byte count
                send_word(bfmh_pkg::kind_t'($urandom_range(2)), key_word(d.tag, j),
                          4'($urandom), 1'b0, 0, none);
                sent++;
            end
            // a broken key now and then: abandoned mid-way by a clear
            if (d.nwords > 1 && $urandom_range(99) == 0) begin
                send_word(bfmh_pkg::KIND_CLEAR, key_word(d.tag, 99), 4'd8, 1'b0, 0, none);
            end else begin
                k = bfmh_pkg::kind_t'($urandom_range(2));
                send_word(k, key_word(d.tag, d.nwords - 1), d.tail_cnt, 1'b1, 0, none);
            end
            sent++;
        end
    endtask

    // ---------------------------------------------------------------
    // Result side: random stall plus one long hold-off
    // ---------------------------------------------------------------
    int  stall_left = 0;
    bit  held_once = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (!held_once && results_seen >= 30) begin
            held_once <= 1'b1;
            stall_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (!quiet && $urandom_range(99) < 25) begin
            stall_left <= ($urandom_range(9) == 0) ? $urandom_range(80, 10)
                                                   : $urandom_range(3);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
        mismatches++;
    endtask

    // Compare each result transaction with the oldest expectation
    always @(posedge aclk) begin
        lookup_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_lookups.size() == 0) begin
                $display("[%0t] result with no expectation pending", $realtime);
                mismatches++;
            end else begin
                want = expected_lookups.pop_front();
                if (m_present !== want.present)
                    report_mismatch("present", 32'(m_present), 32'(want.present));
                if (m_items_total !== want.total)
                    report_mismatch("items_total", m_items_total, want.total);
            end
        end
    end

    // Watchdog: cycles with no transaction on either channel
    int idle_cycles;
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", expected_lookups.size());
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        aresetn <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= bfmh_pkg::REG_NUM_BITS;
        cfg_data <= '0;
        s_valid <= 1'b0;
        s_kind <= bfmh_pkg::KIND_ADD;
        s_data_word <= '0;
        s_byte_count <= '0;
        s_last <= 1'b0;
        quiet = 0;
        next_gap = 0;
        cfg_num_bits = bfmh_pkg::NUM_BITS_RST;
        cfg_num_hashes = bfmh_pkg::NUM_HASHES_RST;
        cfg_seed_first = bfmh_pkg::SEED_FIRST_RST;
        cfg_seed_second = bfmh_pkg::SEED_SECOND_RST;
        wipe_store();
        restart_key();

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table, reset configuration
        build_table();
        foreach (key_table[i])
            send_word(key_table[i].kind, key_table[i].word, key_table[i].cnt,
                      key_table[i].last, key_table[i].typed, key_table[i].res);

        // reset configuration, random keys; the long result hold-off lands here
        random_keys(300, 12);

        // smallest store, one probe, zero seeds
        configure(64'd64, 64'd1, '0, '0);
        random_keys(350, 6);

        // largest store, most probes, all-ones seeds
        configure(64'd65536, 64'd16, '1, '1);
        random_keys(120, 4);

        // out-of-range low values clamp to 64 bits and one probe; no idling here
        configure(64'd0, 64'd0, {$urandom, $urandom}, {$urandom, $urandom});
        quiet = 1;
        random_keys(350, 8);
        quiet = 0;

        // out-of-range high values clamp to the store size and sixteen probes
        configure(64'h1FFFF, 64'h1F, {$urandom, $urandom}, {$urandom, $urandom});
        random_keys(120, 4);

        // mid-range random settings, small probe counts to keep the run short
        configure(64'($urandom_range(65536, 64)), 64'($urandom_range(4, 1)),
                  {$urandom, $urandom}, {$urandom, $urandom});
        random_keys(550, 8);

        drain_block();

        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
